FILE: rtl/pts_pkg.sv
// Package for the plate track speed estimate block.
// Holds shared types, register indexes, codes and reset values; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package pts_pkg;

   localparam int FRAC_BITS = 16;
   localparam int DW        = 64;

   localparam logic [DW-1:0] ONE      = DW'(1) << FRAC_BITS;
   localparam logic [DW-1:0] FRAC_MSK = ONE - DW'(1);

   localparam logic [12:0] FOCAL_RST  = 13'd1770;
   localparam logic [11:0] PWIDTH_RST = 12'd465;
   localparam logic [10:0] CENTER_RST = 11'd480;
   localparam logic [15:0] SCALE_RST  = 16'd7071;

   localparam logic [1:0] ERR_NONE  = 2'd0;
   localparam logic [1:0] ERR_CLAMP = 2'd1;
   localparam logic [1:0] ERR_WIDTH = 2'd2;

   typedef enum logic [7:0] {
      CSR_FOCAL  = 8'd0,
      CSR_PWIDTH = 8'd1,
      CSR_CENTER = 8'd2,
      CSR_SCALE  = 8'd3
   } csr_idx_type;

   typedef enum logic [1:0] {
      ALU_MUL,
      ALU_DIV,
      ALU_SQRT
   } alu_op_type;

   typedef struct packed {
      logic       start;
      alu_op_type op;
   } alu_req_type;

   typedef struct packed {
      logic busy;
      logic done;
   } alu_stat_type;

   typedef struct packed {
      logic [12:0] focal;
      logic [11:0] pwidth;
      logic [10:0] center;
      logic [15:0] scale;
   } cfg_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_HH,
      ST_FF,
      ST_HYP,
      ST_NUM,
      ST_RNG,
      ST_COS,
      ST_CC,
      ST_SIN,
      ST_KC,
      ST_KS,
      ST_DD,
      ST_P,
      ST_Q1,
      ST_Q2,
      ST_T,
      ST_SM,
      ST_SD,
      ST_OUT
   } seq_state_type;

endpackage
`default_nettype wire

FILE: rtl/pts_alu.sv
// Shared bit-serial arithmetic unit: multiply, divide and square root.
// One result bit (or one multiplier bit) per cycle; uses pts_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pts_alu
   import pts_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire alu_req_type  req,
   input  wire logic [DW-1:0] opa,
   input  wire logic [DW-1:0] opb,
   output alu_stat_type      stat,
   output logic [DW-1:0]     result
);

   alu_op_type      op_ff, op_in;
   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [5:0]      cnt_ff, cnt_in;
   logic [DW-1:0]   x_ff, x_in;
   logic [DW-1:0]   y_ff, y_in;
   logic [DW-1:0]   acc_ff, acc_in;
   logic [DW+1:0]   rem_ff, rem_in;
   logic [DW:0]     div_r;
   logic            div_ge;
   logic [DW+1:0]   sq_r;
   logic [DW+1:0]   sq_t;
   logic            sq_ge;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      op_ff  <= op_in;
      cnt_ff <= cnt_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
      acc_ff <= acc_in;
      rem_ff <= rem_in;
   end

   always_comb begin
      div_r  = {rem_ff[DW-1:0], x_ff[DW-1]};
      div_ge = div_r >= {1'b0, y_ff};
      sq_r   = {rem_ff[DW-1:0], x_ff[DW-1:DW-2]};
      sq_t   = {acc_ff, 2'b01};
      sq_ge  = sq_r >= sq_t;

      op_in   = op_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      acc_in  = acc_ff;
      rem_in  = rem_ff;

      if (req.start) begin
         op_in   = req.op;
         busy_in = 1'b1;
         x_in    = opa;
         y_in    = opb;
         acc_in  = '0;
         rem_in  = '0;
         cnt_in  = (req.op == ALU_DIV) ? 6'd63 : 6'd31;
      end else if (busy_ff) begin
         case (op_ff)
            ALU_MUL: begin
               if (y_ff[0]) begin
                  acc_in = acc_ff + x_ff;
               end
               x_in = x_ff << 1;
               y_in = y_ff >> 1;
            end
            ALU_DIV: begin
               rem_in = div_ge ? (DW+2)'(div_r - {1'b0, y_ff}) : (DW+2)'(div_r);
               acc_in = {acc_ff[DW-2:0], div_ge};
               x_in   = x_ff << 1;
            end
            ALU_SQRT: begin
               rem_in = sq_ge ? (sq_r - sq_t) : sq_r;
               acc_in = {acc_ff[DW-2:0], sq_ge};
               x_in   = x_ff << 2;
            end
            default: begin
            end
         endcase
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign result    = acc_ff;

endmodule
`default_nettype wire

FILE: rtl/pts_core.sv
// Sequencer and datapath registers of the speed estimate; drives pts_alu.
// Holds the stored plate and the result register; uses pts_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pts_core
   import pts_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire cfg_type       cfg,
   input  wire logic          in_valid,
   output logic               in_ready,
   input  wire logic          in_found,
   input  wire logic [10:0]   in_x,
   input  wire logic [10:0]   in_width,
   input  wire logic [15:0]   in_frame,
   output logic               out_valid,
   input  wire logic          out_ready,
   output logic               out_speed_valid,
   output logic [23:0]        out_travel,
   output logic [17:0]        out_speed,
   output logic [1:0]         out_err,
   output alu_req_type        alu_req,
   output logic [DW-1:0]      alu_a,
   output logic [DW-1:0]      alu_b,
   input  wire alu_stat_type  alu_stat,
   input  wire logic [DW-1:0] alu_res
);

   seq_state_type state_ff, state_in;
   logic          pend_ff, pend_in;
   logic          sel_ff, sel_in;
   logic          clamp_ff, clamp_in;
   logic [10:0]   x_ff, x_in;
   logic [10:0]   w_ff, w_in;
   logic [15:0]   fi_ff, fi_in;
   logic [10:0]   prev_x_ff, prev_x_in;
   logic [10:0]   prev_w_ff, prev_w_in;
   logic [15:0]   last_fi_ff, last_fi_in;
   logic [DW-1:0] tmp_ff, tmp_in;
   logic [DW-1:0] acc_ff, acc_in;
   logic [DW-1:0] d1_ff, d1_in;
   logic [DW-1:0] d2_ff, d2_in;
   logic [16:0]   c1_ff, c1_in;
   logic [16:0]   c2_ff, c2_in;
   logic [16:0]   s1_ff, s1_in;
   logic [16:0]   s2_ff, s2_in;
   logic [16:0]   m_ff, m_in;
   logic [31:0]   tq_ff, tq_in;
   logic          o_sv_ff, o_sv_in;
   logic [23:0]   o_mm_ff, o_mm_in;
   logic [17:0]   o_sp_ff, o_sp_in;
   logic [1:0]    o_err_ff, o_err_in;

   logic [10:0]   xs;
   logic [10:0]   ws;
   logic [10:0]   h;
   logic [DW-1:0] ds;
   logic [16:0]   cs;
   logic [DW-1:0] fq;
   logic [DW-1:0] big1;
   logic [DW-1:0] big2;
   logic [DW-1:0] diff;
   logic [15:0]   fd;
   logic [DW-1:0] ksum;
   logic [DW-1:0] kcap;
   logic [31:0]   mm_w;
   logic          is_op;
   logic          finish;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         pend_ff    <= 1'b0;
         prev_x_ff  <= '0;
         prev_w_ff  <= '0;
         last_fi_ff <= 16'd1;
      end else begin
         state_ff   <= state_in;
         pend_ff    <= pend_in;
         prev_x_ff  <= prev_x_in;
         prev_w_ff  <= prev_w_in;
         last_fi_ff <= last_fi_in;
      end
      sel_ff   <= sel_in;
      clamp_ff <= clamp_in;
      x_ff     <= x_in;
      w_ff     <= w_in;
      fi_ff    <= fi_in;
      tmp_ff   <= tmp_in;
      acc_ff   <= acc_in;
      d1_ff    <= d1_in;
      d2_ff    <= d2_in;
      c1_ff    <= c1_in;
      c2_ff    <= c2_in;
      s1_ff    <= s1_in;
      s2_ff    <= s2_in;
      m_ff     <= m_in;
      tq_ff    <= tq_in;
      o_sv_ff  <= o_sv_in;
      o_mm_ff  <= o_mm_in;
      o_sp_ff  <= o_sp_in;
      o_err_ff <= o_err_in;
   end

   always_comb begin
      xs   = sel_ff ? x_ff : prev_x_ff;
      ws   = sel_ff ? w_ff : prev_w_ff;
      h    = (xs > cfg.center) ? (xs - cfg.center) : (cfg.center - xs);
      ds   = sel_ff ? d2_ff : d1_ff;
      cs   = sel_ff ? c2_ff : c1_ff;
      fq   = DW'(cfg.focal) << FRAC_BITS;
      big1 = (d1_ff + (DW'(1) << (FRAC_BITS - 5))) >> (FRAC_BITS - 4);
      big2 = (d2_ff + (DW'(1) << (FRAC_BITS - 5))) >> (FRAC_BITS - 4);
      diff = (big1 > big2) ? (big1 - big2) : (big2 - big1);
      fd   = fi_ff - last_fi_ff;
      ksum = (tmp_ff + alu_res) >> FRAC_BITS;
      kcap = (ksum > ONE) ? ONE : ksum;
      mm_w = (alu_res[31:0] + 32'd8) >> 4;
      is_op = (state_ff != ST_IDLE) && (state_ff != ST_OUT);

      state_in   = state_ff;
      pend_in    = pend_ff;
      sel_in     = sel_ff;
      clamp_in   = clamp_ff;
      x_in       = x_ff;
      w_in       = w_ff;
      fi_in      = fi_ff;
      prev_x_in  = prev_x_ff;
      prev_w_in  = prev_w_ff;
      last_fi_in = last_fi_ff;
      tmp_in     = tmp_ff;
      acc_in     = acc_ff;
      d1_in      = d1_ff;
      d2_in      = d2_ff;
      c1_in      = c1_ff;
      c2_in      = c2_ff;
      s1_in      = s1_ff;
      s2_in      = s2_ff;
      m_in       = m_ff;
      tq_in      = tq_ff;
      o_sv_in    = o_sv_ff;
      o_mm_in    = o_mm_ff;
      o_sp_in    = o_sp_ff;
      o_err_in   = o_err_ff;
      finish     = 1'b0;

      alu_req.start = 1'b0;
      alu_req.op    = ALU_MUL;
      alu_a         = '0;
      alu_b         = '0;

      case (state_ff)
         ST_HH:   begin alu_a = DW'(h);            alu_b = DW'(h); end
         ST_FF:   begin alu_a = DW'(cfg.focal);    alu_b = DW'(cfg.focal); end
         ST_HYP:  begin alu_req.op = ALU_SQRT;     alu_a = acc_ff << (2 * FRAC_BITS); end
         ST_NUM:  begin alu_a = tmp_ff;            alu_b = DW'(cfg.pwidth); end
         ST_RNG:  begin alu_req.op = ALU_DIV;      alu_a = acc_ff; alu_b = DW'(ws); end
         ST_COS:  begin
            alu_req.op = ALU_DIV;
            alu_a      = DW'(cfg.focal) << (2 * FRAC_BITS);
            alu_b      = ds;
         end
         ST_CC:   begin alu_a = DW'(cs);           alu_b = DW'(cs); end
         ST_SIN:  begin alu_req.op = ALU_SQRT;     alu_a = tmp_ff; end
         ST_KC:   begin alu_a = DW'(c1_ff);        alu_b = DW'(c2_ff); end
         ST_KS:   begin alu_a = DW'(s1_ff);        alu_b = DW'(s2_ff); end
         ST_DD:   begin alu_a = diff;              alu_b = diff; end
         ST_P:    begin alu_a = big1;              alu_b = big2; end
         ST_Q1:   begin alu_a = tmp_ff >> FRAC_BITS; alu_b = DW'(m_ff); end
         ST_Q2:   begin alu_a = tmp_ff & FRAC_MSK;   alu_b = DW'(m_ff); end
         ST_T:    begin alu_req.op = ALU_SQRT;     alu_a = acc_ff; end
         ST_SM:   begin alu_a = DW'(tq_ff);        alu_b = DW'(cfg.scale); end
         ST_SD:   begin alu_req.op = ALU_DIV;      alu_a = acc_ff; alu_b = DW'(fd) << 12; end
         default: begin end
      endcase

      case (state_ff)
         ST_IDLE: begin
            if (in_valid) begin
               x_in     = in_x;
               w_in     = in_width;
               fi_in    = in_frame;
               sel_in   = 1'b0;
               clamp_in = 1'b0;
               o_sv_in  = 1'b0;
               o_mm_in  = '0;
               o_sp_in  = '0;
               o_err_in = ERR_NONE;
               state_in = ST_OUT;
               if (in_found) begin
                  if (in_width == 11'd0 || prev_w_ff == 11'd0) begin
                     if (in_width == 11'd0) begin
                        o_err_in = ERR_WIDTH;
                     end
                     prev_x_in  = in_x;
                     prev_w_in  = in_width;
                     last_fi_in = in_frame;
                  end else begin
                     state_in = ST_HH;
                  end
               end
            end
         end
         ST_OUT: begin
            if (out_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            if (is_op && !pend_ff) begin
               alu_req.start = 1'b1;
               pend_in       = 1'b1;
            end else if (is_op && alu_stat.done) begin
               pend_in = 1'b0;
               case (state_ff)
                  ST_HH: begin
                     tmp_in   = alu_res;
                     state_in = ST_FF;
                  end
                  ST_FF: begin
                     acc_in   = tmp_ff + alu_res;
                     state_in = ST_HYP;
                  end
                  ST_HYP: begin
                     tmp_in   = alu_res;
                     state_in = ST_NUM;
                  end
                  ST_NUM: begin
                     acc_in   = alu_res + DW'(ws >> 1);
                     state_in = ST_RNG;
                  end
                  ST_RNG: begin
                     if (sel_ff) begin
                        d2_in = alu_res;
                     end else begin
                        d1_in = alu_res;
                     end
                     if (fq >= alu_res) begin
                        if (fq > alu_res) begin
                           clamp_in = 1'b1;
                        end
                        if (sel_ff) begin
                           c2_in    = ONE[16:0];
                           s2_in    = '0;
                           state_in = ST_KC;
                        end else begin
                           c1_in    = ONE[16:0];
                           s1_in    = '0;
                           sel_in   = 1'b1;
                           state_in = ST_HH;
                        end
                     end else begin
                        state_in = ST_COS;
                     end
                  end
                  ST_COS: begin
                     if (sel_ff) begin
                        c2_in = alu_res[16:0];
                     end else begin
                        c1_in = alu_res[16:0];
                     end
                     state_in = ST_CC;
                  end
                  ST_CC: begin
                     tmp_in   = (DW'(1) << (2 * FRAC_BITS)) - alu_res;
                     state_in = ST_SIN;
                  end
                  ST_SIN: begin
                     if (sel_ff) begin
                        s2_in    = alu_res[16:0];
                        state_in = ST_KC;
                     end else begin
                        s1_in    = alu_res[16:0];
                        sel_in   = 1'b1;
                        state_in = ST_HH;
                     end
                  end
                  ST_KC: begin
                     tmp_in   = alu_res;
                     state_in = ST_KS;
                  end
                  ST_KS: begin
                     m_in     = 17'(ONE - kcap);
                     state_in = ST_DD;
                  end
                  ST_DD: begin
                     acc_in   = alu_res;
                     state_in = ST_P;
                  end
                  ST_P: begin
                     tmp_in   = alu_res;
                     state_in = ST_Q1;
                  end
                  ST_Q1: begin
                     acc_in   = acc_ff + (alu_res << 1);
                     state_in = ST_Q2;
                  end
                  ST_Q2: begin
                     acc_in   = acc_ff + ((alu_res >> FRAC_BITS) << 1);
                     state_in = ST_T;
                  end
                  ST_T: begin
                     tq_in   = alu_res[31:0];
                     o_mm_in = (mm_w > 32'h00FF_FFFF) ? 24'hFF_FFFF : mm_w[23:0];
                     if (fd == 16'd0) begin
                        o_sp_in = (alu_res[31:0] != 32'd0) ? 18'h3_FFFF : 18'd0;
                        finish  = 1'b1;
                     end else begin
                        state_in = ST_SM;
                     end
                  end
                  ST_SM: begin
                     acc_in   = alu_res + (DW'(fd) << 11);
                     state_in = ST_SD;
                  end
                  ST_SD: begin
                     o_sp_in = (alu_res > DW'(18'h3_FFFF)) ? 18'h3_FFFF : alu_res[17:0];
                     finish  = 1'b1;
                  end
                  default: begin
                  end
               endcase
               if (finish) begin
                  o_sv_in    = 1'b1;
                  o_err_in   = clamp_ff ? ERR_CLAMP : ERR_NONE;
                  prev_x_in  = x_ff;
                  prev_w_in  = w_ff;
                  last_fi_in = fi_ff;
                  state_in   = ST_OUT;
               end
            end
         end
      endcase
   end

   assign in_ready        = (state_ff == ST_IDLE);
   assign out_valid       = (state_ff == ST_OUT);
   assign out_speed_valid = o_sv_ff;
   assign out_travel      = o_mm_ff;
   assign out_speed       = o_sp_ff;
   assign out_err         = o_err_ff;

endmodule
`default_nettype wire

FILE: rtl/plate_track_speed_estimate.sv
// Plate track speed estimate: one video frame in, one speed result out.
// Channels: req_ (frame beat), rsp_ (result beat), csr_ (register writes).
// rsp_tvalid rises in the cycle after the frame beat when no speed is formed
// (no plate, first plate, zero width). All multiplies, divides and square
// roots run one bit per cycle through the single shared unit pts_alu
// (32 steps per multiply or root, 64 per divide; up to 25 operations per
// speed). req_tready is high only while idle, so one frame is in flight at
// a time. The result beat is held on rsp_ until rsp_tready; a stalled
// receiver simply keeps the block from taking the next frame.
// Reset (synchronous, active high) restores register defaults, clears the
// stored plate and sets the last frame number to one.
// csr_ready is always high; writes to indexes past the list are dropped.
// Depends on pts_pkg, pts_alu and pts_core.
`timescale 1ns / 1ps
`default_nettype none
module plate_track_speed_estimate
   import pts_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,  // plate_x, plate_width, frame_index, zero pad
   input  wire logic        req_tuser,  // plate_found
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [47:0]      rsp_tdata,  // travel_mm, speed_kmph_q8, zero pad
   output logic [2:0]       rsp_tuser,  // speed_valid, error_code
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [7:0]  csr_index,
   input  wire logic [15:0] csr_data
);

   cfg_type       cfg_ff, cfg_in;
   alu_req_type   alu_req;
   alu_stat_type  alu_stat;
   logic [DW-1:0] alu_a;
   logic [DW-1:0] alu_b;
   logic [DW-1:0] alu_res;
   logic          sv;
   logic [23:0]   travel;
   logic [17:0]   speed;
   logic [1:0]    err;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.focal  <= FOCAL_RST;
         cfg_ff.pwidth <= PWIDTH_RST;
         cfg_ff.center <= CENTER_RST;
         cfg_ff.scale  <= SCALE_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_FOCAL:  cfg_in.focal  = csr_data[12:0];
            CSR_PWIDTH: cfg_in.pwidth = csr_data[11:0];
            CSR_CENTER: cfg_in.center = csr_data[10:0];
            CSR_SCALE:  cfg_in.scale  = csr_data;
            default:    begin end
         endcase
      end
   end

   assign csr_ready = 1'b1;

   pts_alu u_alu (
      .clock  (clock),
      .reset  (reset),
      .req    (alu_req),
      .opa    (alu_a),
      .opb    (alu_b),
      .stat   (alu_stat),
      .result (alu_res)
   );

   pts_core u_core (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .in_valid        (req_tvalid),
      .in_ready        (req_tready),
      .in_found        (req_tuser),
      .in_x            (req_tdata[10:0]),
      .in_width        (req_tdata[21:11]),
      .in_frame        (req_tdata[37:22]),
      .out_valid       (rsp_tvalid),
      .out_ready       (rsp_tready),
      .out_speed_valid (sv),
      .out_travel      (travel),
      .out_speed       (speed),
      .out_err         (err),
      .alu_req         (alu_req),
      .alu_a           (alu_a),
      .alu_b           (alu_b),
      .alu_stat        (alu_stat),
      .alu_res         (alu_res)
   );

   assign rsp_tdata = {6'd0, speed, travel};
   assign rsp_tuser = {err, sv};

endmodule
`default_nettype wire

FILE: rtl/pts_checker.sv
// Port-level checks for plate_track_speed_estimate, bound to the top level.
// Depends on pts_pkg for the error codes.
`timescale 1ns / 1ps
`default_nettype none
module pts_checker
   import pts_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [47:0] rsp_tdata,
   input wire logic [2:0]  rsp_tuser
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp beat dropped while stalled");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second frame taken while busy");

   a_one_side: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("ready for a frame while a result waits");

   a_no_speed_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == 48'd0)
      else $error("nonzero fields without a speed");

   a_width_err: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[2:1] == ERR_WIDTH |-> !rsp_tuser[0])
      else $error("speed flagged on zero width");

endmodule

bind plate_track_speed_estimate pts_checker u_pts_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
`default_nettype wire

FILE: bench/pts_checker.sv
// Result checker for the plate track speed estimate block.
// Watches the frame, result and register channels, predicts each result; depends on pts_pkg.
`timescale 1ns / 1ps
module pts_scoreboard
   import pts_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [39:0] req_tdata,
   input  wire logic        req_tuser,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [47:0] rsp_tdata,
   input  wire logic [2:0]  rsp_tuser,
   input  wire logic        csr_valid,
   input  wire logic        csr_ready,
   input  wire logic [7:0]  csr_index,
   input  wire logic [15:0] csr_data,
   output int               fail_count,
   output int               pending
);
   typedef struct packed {
      logic        spd_ok;
      logic [23:0] travel;
      logic [17:0] speed;
      logic [1:0]  err;
   } speed_result_type;

   speed_result_type expected_q[$];
   logic [63:0] foc, pw, cen, scl;
   logic [63:0] st_x, st_w, st_fi;

   function automatic logic [63:0] root_of(logic [63:0] a, int k);
      logic [63:0] r, rem, tr, pr;
      r = '0;
      rem = '0;
      for (int n = 0; n < 32 + k; n++) begin
         pr = (n < 32) ? ((a >> (2 * (31 - n))) & 64'd3) : 64'd0;
         rem = (rem << 2) | pr;
         tr = (r << 2) | 64'd1;
         if (rem >= tr) begin
            rem = rem - tr;
            r = (r << 1) | 64'd1;
         end else begin
            r = r << 1;
         end
      end
      return r;
   endfunction

   function automatic logic [63:0] range_q(logic [63:0] x, logic [63:0] w);
      logic [63:0] h;
      h = (x > cen) ? x - cen : cen - x;
      return (root_of(h * h + foc * foc, 16) * pw + w / 2) / w;
   endfunction

   function automatic void bearing(input logic [63:0] d, output logic [63:0] c,
                                   output logic [63:0] s, inout logic clamp);
      logic [63:0] fq;
      fq = foc << 16;
      if (fq >= d) begin
         if (fq > d) clamp = 1'b1;
         c = ONE;
         s = '0;
      end else begin
         c = (foc << 32) / d;
         s = root_of(ONE * ONE - c * c, 0);
      end
   endfunction

   function automatic speed_result_type predict_speed(logic fnd, logic [63:0] x,
                                                      logic [63:0] w, logic [63:0] fi);
      speed_result_type r;
      logic [63:0] d1, d2, c1, s1, c2, s2, k, m, b1, b2, df, p, pr, tq, mm, fd, sp;
      logic clamp;
      r = '0;
      clamp = 1'b0;
      if (!fnd) return r;
      if (w == 0) begin
         r.err = ERR_WIDTH;
      end else if (st_w != 0) begin
         d1 = range_q(st_x, st_w);
         d2 = range_q(x, w);
         bearing(d1, c1, s1, clamp);
         bearing(d2, c2, s2, clamp);
         k = (c1 * c2 + s1 * s2) >> 16;
         if (k > ONE) k = ONE;
         m = ONE - k;
         b1 = (d1 + 64'd2048) >> 12;
         b2 = (d2 + 64'd2048) >> 12;
         df = (b1 > b2) ? b1 - b2 : b2 - b1;
         p = b1 * b2;
         pr = (p >> 16) * m + (((p & FRAC_MSK) * m) >> 16);
         tq = root_of(df * df + 2 * pr, 0);
         mm = (tq + 8) >> 4;
         if (mm > 64'hFFFFFF) mm = 64'hFFFFFF;
         fd = (fi - st_fi) & 64'hFFFF;
         if (fd == 0) begin
            sp = (tq != 0) ? 64'h3FFFF : 64'd0;
         end else begin
            sp = (tq * scl + (fd << 11)) / (fd << 12);
            if (sp > 64'h3FFFF) sp = 64'h3FFFF;
         end
         r.spd_ok = 1'b1;
         r.travel = mm[23:0];
         r.speed = sp[17:0];
         r.err = clamp ? ERR_CLAMP : ERR_NONE;
      end
      st_x = x;
      st_w = w;
      st_fi = fi;
      return r;
   endfunction

   always @(posedge clock) begin
      speed_result_type got, exp_r;
      if (reset) begin
         foc <= 64'(FOCAL_RST);
         pw <= 64'(PWIDTH_RST);
         cen <= 64'(CENTER_RST);
         scl <= 64'(SCALE_RST);
         st_x = '0;
         st_w = '0;
         st_fi = 64'd1;
         expected_q.delete();
         fail_count <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_FOCAL:  foc <= 64'(csr_data[12:0]);
               CSR_PWIDTH: pw <= 64'(csr_data[11:0]);
               CSR_CENTER: cen <= 64'(csr_data[10:0]);
               CSR_SCALE:  scl <= 64'(csr_data);
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            expected_q.push_back(predict_speed(req_tuser, 64'(req_tdata[10:0]),
                                               64'(req_tdata[21:11]),
                                               64'(req_tdata[37:22])));
         if (rsp_tvalid && rsp_tready) begin
            got.spd_ok = rsp_tuser[0];
            got.err = rsp_tuser[2:1];
            got.travel = rsp_tdata[23:0];
            got.speed = rsp_tdata[41:24];
            if (expected_q.size() == 0) begin
               if (fail_count < 10) $display("unexpected result beat %h", got);
               fail_count <= fail_count + 1;
            end else begin
               exp_r = expected_q.pop_front();
               if (got !== exp_r || rsp_tdata[47:42] !== 6'd0) begin
                  if (fail_count < 10)
                     $display({"mismatch: exp valid %0d travel %0d speed %0d err %0d, ",
                               "got valid %0d travel %0d speed %0d err %0d"},
                              exp_r.spd_ok, exp_r.travel, exp_r.speed, exp_r.err,
                              got.spd_ok, got.travel, got.speed, got.err);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
      pending <= expected_q.size();
   end
endmodule

FILE: bench/tb_plate_track_speed_estimate.sv
// Testbench top for the plate track speed estimate block.
// Drives frames and register writes, stalls the receiver; depends on pts_pkg and pts_checker.
`timescale 1ns / 1ps
module tb_plate_track_speed_estimate;
   import pts_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_index = '0;
   logic [15:0] csr_data = '0;
   int          fail_count, pending;
   int          quiet_cycles = 0;
   bit          hold_rsp = 1'b0;
   logic [15:0] frame_cnt = 16'd2;

   localparam int QUIET_LIMIT = 40000;

   always #4 clock = ~clock;

   plate_track_speed_estimate u_dut (.*);

   pts_scoreboard u_chk (.*);

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   function automatic int gap_len();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(20, 200) : $urandom_range(0, 3);
   endfunction

   always @(posedge clock) begin
      if (hold_rsp) rsp_tready <= 1'b0;
      else rsp_tready <= ($urandom_range(0, 3) != 0);
   end

   task automatic send_frame(logic fnd, logic [10:0] x, logic [10:0] w, logic [15:0] fi,
                             bit gaps);
      int g;
      g = gaps ? gap_len() : 0;
      repeat (g + 1) @(posedge clock);
      req_tvalid <= 1'b1;
      req_tuser <= fnd;
      req_tdata <= {2'b00, fi, w, x};
      do @(posedge clock); while (!req_tready);
      req_tvalid <= 1'b0;
   endtask

   task automatic write_reg(csr_idx_type idx, logic [15:0] val);
      while (pending != 0) @(posedge clock);
      repeat (1100) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic random_phase(int n);
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(0, 19))
            0: send_frame(1'b0, 11'($urandom), 11'($urandom), 16'($urandom), 1);
            1: send_frame(1'b1, 11'($urandom), 11'd0, frame_cnt, 1);
            2: send_frame(1'b1, 11'($urandom), 11'($urandom), 16'($urandom), 1);
            default: send_frame(1'b1, 11'($urandom), 11'($urandom_range(1, 400)),
                                frame_cnt, 1);
         endcase
         frame_cnt = frame_cnt + (($urandom_range(0, 9) == 0) ?
                                  16'($urandom_range(0, 5)) : 16'd1);
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_frame(1'b0, 11'h7FF, 11'h7FF, 16'hFFFF, 0);
      send_frame(1'b1, 11'd400, 11'd120, 16'd1, 0);
      send_frame(1'b1, 11'd450, 11'd130, 16'd2, 0);
      send_frame(1'b1, 11'd0, 11'd1, 16'd3, 0);
      send_frame(1'b1, 11'h7FF, 11'h7FF, 16'd4, 0);
      send_frame(1'b1, 11'd480, 11'd200, 16'd4, 0);
      send_frame(1'b1, 11'd480, 11'd0, 16'd5, 0);
      send_frame(1'b1, 11'd100, 11'd100, 16'd6, 0);
      send_frame(1'b1, 11'd2000, 11'd1, 16'hFFFF, 0);
      send_frame(1'b1, 11'd480, 11'd465, 16'd0, 0);
      send_frame(1'b1, 11'd480, 11'd466, 16'd1, 0);
      send_frame(1'b1, 11'd900, 11'd50, 16'd1, 0);
      random_phase(350);
      write_reg(CSR_FOCAL, 16'd1);
      write_reg(CSR_PWIDTH, 16'd4095);
      write_reg(CSR_CENTER, 16'd0);
      write_reg(CSR_SCALE, 16'hFFFF);
      random_phase(300);
      write_reg(CSR_FOCAL, 16'd8191);
      write_reg(CSR_PWIDTH, 16'd1);
      write_reg(CSR_CENTER, 16'd2047);
      write_reg(CSR_SCALE, 16'd0);
      random_phase(200);
      write_reg(CSR_FOCAL, 16'd0);
      write_reg(CSR_PWIDTH, 16'd0);
      write_reg(CSR_CENTER, 16'd960);
      write_reg(csr_idx_type'(8'd9), 16'hFFFF);
      random_phase(60);
      write_reg(CSR_FOCAL, 16'd1770);
      write_reg(CSR_PWIDTH, 16'd465);
      write_reg(CSR_SCALE, 16'd7071);
      fork
         begin
            hold_rsp <= 1'b1;
            repeat (3000) @(posedge clock);
            hold_rsp <= 1'b0;
         end
         random_phase(5);
      join
      random_phase(580);
      while (pending != 0) @(posedge clock);
      repeat (1100) @(posedge clock);
      if (fail_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end
endmodule

FILE: plate_track_speed_estimate.f
rtl/pts_pkg.sv
rtl/pts_alu.sv
rtl/pts_core.sv
rtl/plate_track_speed_estimate.sv
rtl/pts_checker.sv
bench/pts_checker.sv
bench/tb_plate_track_speed_estimate.sv
